/* sv/svpwm_pkg.sv */
package svpwm_pkg;

	localparam int FRAC_BITS = 14;
	localparam int ONE = 1 << FRAC_BITS;

	// sqrt(3)/2 in 0.32, rounded to FRAC_BITS fraction bits
	localparam longint unsigned SQ3H_Q32 = 64'd3719550786;
	localparam int SQ3H = int'((SQ3H_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));

	localparam int DATA_W = 16;
	localparam int PER_W = 16;
	localparam int MAG_W = DATA_W;
	localparam int SQ_W = 2 * DATA_W;
	localparam int DVD_W = MAG_W + FRAC_BITS;
	localparam int DSR_W = SQ_W - FRAC_BITS;
	localparam int REM_W = DSR_W + 1;
	localparam int QUO_W = 16;
	localparam int NORM_W = QUO_W + 1;
	localparam int DIV_STEP = 2;
	localparam int DIV_STAGES = QUO_W / DIV_STEP;
	localparam int REF_W = 19;
	localparam int TPROD_W = 40;
	localparam int TIME_W = 22;
	localparam int SUM_W = TIME_W + 2;

	localparam logic OP_AB = 1'b0;
	localparam logic OP_BASIC = 1'b1;

	localparam logic [2:0] SEC_ZERO = 3'd0;

	typedef enum logic [1:0] {
		ROLE_MIN,
		ROLE_MID,
		ROLE_MAX
	} role_t;

	typedef enum logic [1:0] {
		REF_ONE,
		REF_TWO,
		REF_THREE
	} ref_sel_t;

	typedef struct packed {
		ref_sel_t ref_first;
		ref_sel_t ref_second;
		logic negate;
		role_t role_a;
		role_t role_b;
		role_t role_c;
	} sec_info_t;

	typedef struct packed {
		logic valid;
		logic [2:0] sector;
	} sec_ctl_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] one;
		logic signed [DATA_W-1:0] two;
		logic signed [DATA_W-1:0] three;
	} refs_t;

	function automatic logic [2:0] sector_map(input logic [2:0] pseudo);
		case (pseudo)
			3'd1: return 3'd2;
			3'd2: return 3'd6;
			3'd3: return 3'd1;
			3'd4: return 3'd4;
			3'd5: return 3'd3;
			3'd6: return 3'd5;
			default: return SEC_ZERO;
		endcase
	endfunction

	function automatic sec_info_t sector_info(input logic [2:0] sec);
		case (sec)
			3'd1: return '{REF_ONE, REF_THREE, 1'b0, ROLE_MIN, ROLE_MID, ROLE_MAX};
			3'd2: return '{REF_THREE, REF_TWO, 1'b1, ROLE_MID, ROLE_MIN, ROLE_MAX};
			3'd3: return '{REF_TWO, REF_ONE, 1'b0, ROLE_MAX, ROLE_MIN, ROLE_MID};
			3'd4: return '{REF_ONE, REF_THREE, 1'b1, ROLE_MAX, ROLE_MID, ROLE_MIN};
			3'd5: return '{REF_THREE, REF_TWO, 1'b0, ROLE_MID, ROLE_MAX, ROLE_MIN};
			3'd6: return '{REF_TWO, REF_ONE, 1'b1, ROLE_MIN, ROLE_MAX, ROLE_MID};
			default: return '{REF_ONE, REF_ONE, 1'b0, ROLE_MIN, ROLE_MIN, ROLE_MIN};
		endcase
	endfunction

	// shift right by FRAC_BITS, rounding toward zero
	function automatic logic signed [63:0] shr_trunc(input logic signed [63:0] x);
		logic [63:0] m;
		m = x[63] ? 64'(-x) : 64'(x);
		m = m >> FRAC_BITS;
		return x[63] ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic signed [63:0] half_trunc(input logic signed [63:0] x);
		return x / 64'sd2;
	endfunction

	function automatic logic signed [DATA_W-1:0] sat16s(input logic signed [REF_W-1:0] x);
		if (x > 32767) begin
			return 16'sh7fff;
		end else if (x < -32768) begin
			return 16'sh8000;
		end else begin
			return DATA_W'(x);
		end
	endfunction

	function automatic logic [15:0] sat16u(input logic [SUM_W-1:0] x);
		return (x > SUM_W'(16'hffff)) ? 16'hffff : x[15:0];
	endfunction

endpackage

/* sv/svpwm_input.sv */
module svpwm_input import svpwm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic opcode,
	input logic signed [DATA_W-1:0] alpha_in,
	input logic signed [DATA_W-1:0] beta_in,
	input logic [2:0] vector_number,
	input logic signed [DATA_W-1:0] power_level,
	output logic valid,
	output logic norm,
	output logic [DSR_W-1:0] divisor,
	output logic [MAG_W-1:0] alpha_mag,
	output logic [MAG_W-1:0] beta_mag,
	output logic alpha_neg,
	output logic beta_neg,
	output logic signed [DATA_W-1:0] alpha,
	output logic signed [DATA_W-1:0] beta
);

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic op_s1;
	logic signed [DATA_W-1:0] ain_s1, bin_s1, p_s1;
	logic [2:0] vn_s1;
	logic signed [31:0] prod_s1;
	logic signed [DATA_W-1:0] p_c, ph_c, ps_c, a_c, b_c;
	logic signed [DATA_W-1:0] a_s2, b_s2, a_s3, b_s3, a_s4, b_s4;
	logic [SQ_W-1:0] sqa_s3, sqb_s3, q_c;
	logic norm_s4, aneg_s4, bneg_s4;
	logic [DSR_W-1:0] n_s4;
	logic [MAG_W-1:0] amag_s4, bmag_s4;

	// power clamp to plus or minus one
	always_comb begin
		if (power_level > ONE) begin
			p_c = DATA_W'(ONE);
		end else if (power_level < -ONE) begin
			p_c = DATA_W'(-ONE);
		end else begin
			p_c = power_level;
		end
	end

	always_comb begin
		ph_c = DATA_W'(half_trunc(64'(p_s1)));
		ps_c = DATA_W'(shr_trunc(64'(prod_s1)));
		a_c = '0;
		b_c = '0;
		if (op_s1 == OP_AB) begin
			a_c = ain_s1;
			b_c = bin_s1;
		end else begin
			case (vn_s1)
				3'd1: begin a_c = p_s1; b_c = '0; end
				3'd2: begin a_c = ph_c; b_c = ps_c; end
				3'd3: begin a_c = -ph_c; b_c = ps_c; end
				3'd4: begin a_c = -p_s1; b_c = '0; end
				3'd5: begin a_c = -ph_c; b_c = -ps_c; end
				3'd6: begin a_c = ph_c; b_c = -ps_c; end
				default: begin a_c = '0; b_c = '0; end
			endcase
		end
	end

	assign q_c = sqa_s3 + sqb_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		op_s1 <= opcode;
		ain_s1 <= alpha_in;
		bin_s1 <= beta_in;
		vn_s1 <= vector_number;
		p_s1 <= p_c;
		prod_s1 <= 32'(p_c) * SQ3H;

		a_s2 <= a_c;
		b_s2 <= b_c;

		a_s3 <= a_s2;
		b_s3 <= b_s2;
		sqa_s3 <= SQ_W'(32'(a_s2) * 32'(a_s2));
		sqb_s3 <= SQ_W'(32'(b_s2) * 32'(b_s2));

		a_s4 <= a_s3;
		b_s4 <= b_s3;
		norm_s4 <= q_c > (SQ_W'(ONE) << FRAC_BITS);
		n_s4 <= DSR_W'(q_c >> FRAC_BITS);
		aneg_s4 <= a_s3[DATA_W-1];
		bneg_s4 <= b_s3[DATA_W-1];
		amag_s4 <= a_s3[DATA_W-1] ? MAG_W'(-a_s3) : MAG_W'(a_s3);
		bmag_s4 <= b_s3[DATA_W-1] ? MAG_W'(-b_s3) : MAG_W'(b_s3);
	end

	assign valid = vld_s4;
	assign norm = norm_s4;
	assign divisor = n_s4;
	assign alpha_mag = amag_s4;
	assign beta_mag = bmag_s4;
	assign alpha_neg = aneg_s4;
	assign beta_neg = bneg_s4;
	assign alpha = a_s4;
	assign beta = b_s4;

endmodule

/* sv/svpwm_div.sv */
module svpwm_div import svpwm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [DVD_W-1:0] dividend,
	input logic [DSR_W-1:0] divisor,
	input logic neg,
	output logic out_valid,
	output logic signed [NORM_W-1:0] quotient
);

	// restoring division, quotient known to fit QUO_W bits
	logic [REM_W-1:0] rem_sd [DIV_STAGES];
	logic [QUO_W-1:0] low_sd [DIV_STAGES];
	logic [QUO_W-1:0] quo_sd [DIV_STAGES];
	logic [DSR_W-1:0] dsr_sd [DIV_STAGES];
	logic neg_sd [DIV_STAGES];
	logic vld_sd [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [REM_W-1:0] rem_in, rem_c;
		logic [QUO_W-1:0] low_in, low_c, quo_in, quo_c;
		logic [DSR_W-1:0] dsr_in;
		logic neg_in, vld_in;

		if (k == 0) begin : g_first
			assign rem_in = REM_W'(dividend >> QUO_W);
			assign low_in = dividend[QUO_W-1:0];
			assign quo_in = '0;
			assign dsr_in = divisor;
			assign neg_in = neg;
			assign vld_in = in_valid;
		end else begin : g_next
			assign rem_in = rem_sd[k-1];
			assign low_in = low_sd[k-1];
			assign quo_in = quo_sd[k-1];
			assign dsr_in = dsr_sd[k-1];
			assign neg_in = neg_sd[k-1];
			assign vld_in = vld_sd[k-1];
		end

		always_comb begin
			rem_c = rem_in;
			low_c = low_in;
			quo_c = quo_in;
			for (int i = 0; i < DIV_STEP; i++) begin
				rem_c = {rem_c[REM_W-2:0], low_c[QUO_W-1]};
				low_c = {low_c[QUO_W-2:0], 1'b0};
				if (rem_c >= REM_W'(dsr_in)) begin
					rem_c = rem_c - REM_W'(dsr_in);
					quo_c = {quo_c[QUO_W-2:0], 1'b1};
				end else begin
					quo_c = {quo_c[QUO_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sd[k] <= 1'b0;
			end else begin
				vld_sd[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_sd[k] <= rem_c;
			low_sd[k] <= low_c;
			quo_sd[k] <= quo_c;
			dsr_sd[k] <= dsr_in;
			neg_sd[k] <= neg_in;
		end
	end

	assign out_valid = vld_sd[DIV_STAGES-1];
	assign quotient = neg_sd[DIV_STAGES-1] ? -$signed({1'b0, quo_sd[DIV_STAGES-1]})
		: $signed({1'b0, quo_sd[DIV_STAGES-1]});

endmodule

/* sv/svpwm_sector.sv */
module svpwm_sector import svpwm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic norm,
	input logic signed [DATA_W-1:0] alpha_raw,
	input logic signed [DATA_W-1:0] beta_raw,
	input logic signed [NORM_W-1:0] alpha_quo,
	input logic signed [NORM_W-1:0] beta_quo,
	output sec_ctl_t ctl,
	output logic signed [REF_W-1:0] r1,
	output logic signed [REF_W-1:0] r2,
	output refs_t refs
);

	logic vld_s5;
	logic signed [NORM_W-1:0] a_c, b_c, beta_s5, bn_s5;
	logic signed [31:0] prod_s5;
	logic signed [REF_W-1:0] sh_c, ref1_c, ref2_c, ref3_c, r1_c, r2_c;
	logic [2:0] sec_c;
	sec_info_t info_c;
	sec_ctl_t ctl_s6;
	logic signed [REF_W-1:0] r1_s6, r2_s6;
	refs_t refs_s6;

	function automatic logic signed [REF_W-1:0] pick(input ref_sel_t sel,
		input logic signed [REF_W-1:0] x1, input logic signed [REF_W-1:0] x2,
		input logic signed [REF_W-1:0] x3);
		case (sel)
			REF_TWO: return x2;
			REF_THREE: return x3;
			default: return x1;
		endcase
	endfunction

	assign a_c = norm ? alpha_quo : NORM_W'(alpha_raw);
	assign b_c = norm ? beta_quo : NORM_W'(beta_raw);

	always_comb begin
		sh_c = REF_W'(shr_trunc(64'(prod_s5)));
		ref1_c = REF_W'(beta_s5);
		ref2_c = REF_W'(bn_s5) - sh_c;
		ref3_c = REF_W'(bn_s5) + sh_c;
		sec_c = sector_map({ref2_c > 0, ref3_c > 0, ref1_c > 0});
		info_c = sector_info(sec_c);
		r1_c = pick(info_c.ref_first, ref1_c, ref2_c, ref3_c);
		r2_c = pick(info_c.ref_second, ref1_c, ref2_c, ref3_c);
		if (info_c.negate) begin
			r1_c = -r1_c;
			r2_c = -r2_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			ctl_s6 <= '0;
		end else begin
			vld_s5 <= in_valid;
			ctl_s6.valid <= vld_s5;
			ctl_s6.sector <= sec_c;
		end
	end

	always_ff @(posedge clk) begin
		beta_s5 <= b_c;
		bn_s5 <= -NORM_W'(half_trunc(64'(b_c)));
		prod_s5 <= 32'(a_c) * SQ3H;

		r1_s6 <= r1_c;
		r2_s6 <= r2_c;
		refs_s6.one <= sat16s(ref1_c);
		refs_s6.two <= sat16s(ref2_c);
		refs_s6.three <= sat16s(ref3_c);
	end

	assign ctl = ctl_s6;
	assign r1 = r1_s6;
	assign r2 = r2_s6;
	assign refs = refs_s6;

endmodule

/* sv/svpwm_times.sv */
module svpwm_times import svpwm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input sec_ctl_t ctl,
	input logic signed [REF_W-1:0] r1,
	input logic signed [REF_W-1:0] r2,
	input refs_t refs,
	input logic [PER_W-1:0] period,
	output logic done,
	output logic [15:0] compare_a,
	output logic [15:0] compare_b,
	output logic [15:0] compare_c,
	output logic [2:0] sector_out,
	output refs_t refs_out,
	output logic overmodulation
);

	sec_ctl_t ctl_s7, ctl_s8;
	refs_t refs_s7, refs_s8, refs_s9;
	logic signed [TPROD_W-1:0] t1p_s7, t2p_s7;
	logic signed [63:0] t1_c, t2_c;
	logic [TIME_W-1:0] u1_c, u2_c, sum_c, u1_s8, u2_s8;
	logic ovm_c, ovm_s8, ovm_s9, done_s9;
	logic [PER_W-1:0] tmin_c, tmin_s8;
	sec_info_t info_c;
	logic [SUM_W-1:0] tvar_c, tmax_c;
	logic [15:0] tm_min, tm_mid, tm_max;
	logic [15:0] ca_c, cb_c, cc_c, ca_s9, cb_s9, cc_s9;
	logic [2:0] sec_s9;

	function automatic logic [15:0] by_role(input role_t r, input logic [15:0] vmin,
		input logic [15:0] vmid, input logic [15:0] vmax);
		case (r)
			ROLE_MID: return vmid;
			ROLE_MAX: return vmax;
			default: return vmin;
		endcase
	endfunction

	always_comb begin
		t1_c = shr_trunc(64'(t1p_s7));
		t2_c = shr_trunc(64'(t2p_s7));
		u1_c = t1_c[63] ? '0 : TIME_W'(t1_c);
		u2_c = t2_c[63] ? '0 : TIME_W'(t2_c);
		sum_c = u1_c + u2_c;
		ovm_c = sum_c > TIME_W'(period);
		tmin_c = ovm_c ? '0 : PER_W'((TIME_W'(period) - sum_c) >> 1);
	end

	always_comb begin
		info_c = sector_info(ctl_s8.sector);
		// even-numbered sectors negate and put the first active time in the middle
		if (info_c.negate) begin
			tvar_c = SUM_W'(tmin_s8) + SUM_W'(u1_s8);
			tmax_c = tvar_c + SUM_W'(u2_s8);
		end else begin
			tvar_c = SUM_W'(tmin_s8) + SUM_W'(u2_s8);
			tmax_c = tvar_c + SUM_W'(u1_s8);
		end
		tm_min = sat16u(SUM_W'(tmin_s8));
		tm_mid = sat16u(tvar_c);
		tm_max = sat16u(tmax_c);
		if (ctl_s8.sector == SEC_ZERO) begin
			ca_c = '0;
			cb_c = '0;
			cc_c = '0;
		end else begin
			ca_c = by_role(info_c.role_a, tm_min, tm_mid, tm_max);
			cb_c = by_role(info_c.role_b, tm_min, tm_mid, tm_max);
			cc_c = by_role(info_c.role_c, tm_min, tm_mid, tm_max);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s7 <= '0;
			ctl_s8 <= '0;
			done_s9 <= 1'b0;
		end else begin
			ctl_s7 <= ctl;
			ctl_s8 <= ctl_s7;
			done_s9 <= ctl_s8.valid;
		end
	end

	always_ff @(posedge clk) begin
		t1p_s7 <= TPROD_W'(r1) * $signed(TPROD_W'(period));
		t2p_s7 <= TPROD_W'(r2) * $signed(TPROD_W'(period));
		refs_s7 <= refs;

		u1_s8 <= u1_c;
		u2_s8 <= u2_c;
		tmin_s8 <= tmin_c;
		ovm_s8 <= ovm_c;
		refs_s8 <= refs_s7;

		ca_s9 <= ca_c;
		cb_s9 <= cb_c;
		cc_s9 <= cc_c;
		sec_s9 <= ctl_s8.sector;
		ovm_s9 <= (ctl_s8.sector != SEC_ZERO) && ovm_s8;
		refs_s9 <= refs_s8;
	end

	assign done = done_s9;
	assign compare_a = ca_s9;
	assign compare_b = cb_s9;
	assign compare_c = cc_s9;
	assign sector_out = sec_s9;
	assign refs_out = refs_s9;
	assign overmodulation = ovm_s9;

endmodule

/* sv/svpwm_compare_calculator.sv */
// channel   | handshake           | payload
// ----------+---------------------+-------------------------------------------------
// request   | start, busy         | opcode, alpha_in, beta_in, vector_number,
//           |                     | power_level
// result    | done (one cycle)    | compare_a/b/c, sector_out, phase_ref_one/two/three,
//           |                     | overmodulation
// config    | cfg_we              | cfg_wdata (timer period)
//
// one request per cycle; busy stays low
// a result passes through 4 input stages, 8 divider stages of two quotient bits each,
// 2 sector stages and 3 timing stages
// reset clears all valid bits and loads the period register with 4096
// the receiver takes every result as it comes, so nothing stalls
module svpwm_compare_calculator import svpwm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic opcode,
	input logic signed [DATA_W-1:0] alpha_in,
	input logic signed [DATA_W-1:0] beta_in,
	input logic [2:0] vector_number,
	input logic signed [DATA_W-1:0] power_level,
	input logic cfg_we,
	input logic [PER_W-1:0] cfg_wdata,
	output logic done,
	output logic [15:0] compare_a,
	output logic [15:0] compare_b,
	output logic [15:0] compare_c,
	output logic [2:0] sector_out,
	output logic signed [DATA_W-1:0] phase_ref_one,
	output logic signed [DATA_W-1:0] phase_ref_two,
	output logic signed [DATA_W-1:0] phase_ref_three,
	output logic overmodulation
);

	localparam int LATENCY = 4 + DIV_STAGES + 5;

	logic [PER_W-1:0] period_q;
	logic in_vld, in_norm, aneg, bneg;
	logic [DSR_W-1:0] divisor;
	logic [MAG_W-1:0] amag, bmag;
	logic signed [DATA_W-1:0] a_raw, b_raw;
	logic div_vld, div_vld_b;
	logic signed [NORM_W-1:0] a_quo, b_quo;
	logic norm_sd [DIV_STAGES];
	logic signed [DATA_W-1:0] a_sd [DIV_STAGES];
	logic signed [DATA_W-1:0] b_sd [DIV_STAGES];
	sec_ctl_t sec_ctl;
	logic signed [REF_W-1:0] r1, r2;
	refs_t refs, refs_out;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PER_W'(4096);
		end else if (cfg_we) begin
			period_q <= cfg_wdata;
		end
	end

	svpwm_input u_input (
		.clk(clk),
		.arst_n(arst_n),
		.start(start && !busy),
		.opcode(opcode),
		.alpha_in(alpha_in),
		.beta_in(beta_in),
		.vector_number(vector_number),
		.power_level(power_level),
		.valid(in_vld),
		.norm(in_norm),
		.divisor(divisor),
		.alpha_mag(amag),
		.beta_mag(bmag),
		.alpha_neg(aneg),
		.beta_neg(bneg),
		.alpha(a_raw),
		.beta(b_raw)
	);

	svpwm_div u_div_alpha (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_vld),
		.dividend({amag, {FRAC_BITS{1'b0}}}),
		.divisor(divisor),
		.neg(aneg),
		.out_valid(div_vld),
		.quotient(a_quo)
	);

	svpwm_div u_div_beta (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_vld),
		.dividend({bmag, {FRAC_BITS{1'b0}}}),
		.divisor(divisor),
		.neg(bneg),
		.out_valid(div_vld_b),
		.quotient(b_quo)
	);

	// unnormalized vector rides alongside the divider
	always_ff @(posedge clk) begin
		norm_sd[0] <= in_norm;
		a_sd[0] <= a_raw;
		b_sd[0] <= b_raw;
		for (int k = 1; k < DIV_STAGES; k++) begin
			norm_sd[k] <= norm_sd[k-1];
			a_sd[k] <= a_sd[k-1];
			b_sd[k] <= b_sd[k-1];
		end
	end

	svpwm_sector u_sector (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(div_vld),
		.norm(norm_sd[DIV_STAGES-1]),
		.alpha_raw(a_sd[DIV_STAGES-1]),
		.beta_raw(b_sd[DIV_STAGES-1]),
		.alpha_quo(a_quo),
		.beta_quo(b_quo),
		.ctl(sec_ctl),
		.r1(r1),
		.r2(r2),
		.refs(refs)
	);

	svpwm_times u_times (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(sec_ctl),
		.r1(r1),
		.r2(r2),
		.refs(refs),
		.period(period_q),
		.done(done),
		.compare_a(compare_a),
		.compare_b(compare_b),
		.compare_c(compare_c),
		.sector_out(sector_out),
		.refs_out(refs_out),
		.overmodulation(overmodulation)
	);

	assign phase_ref_one = refs_out.one;
	assign phase_ref_two = refs_out.two;
	assign phase_ref_three = refs_out.three;

	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result without a request");

	a_div_lanes_agree: assert property (@(posedge clk) disable iff (!arst_n)
		div_vld == div_vld_b)
		else $error("divider lanes out of step");

	a_ovm_needs_sector: assert property (@(posedge clk) disable iff (!arst_n)
		(done && overmodulation) |-> (sector_out != SEC_ZERO))
		else $error("overmodulation in zero sector");

	a_zero_sector_compares: assert property (@(posedge clk) disable iff (!arst_n)
		(done && sector_out == SEC_ZERO) |->
		(compare_a == 16'd0 && compare_b == 16'd0 && compare_c == 16'd0))
		else $error("zero sector with nonzero compares");

endmodule

/* tb/svpwm_compare_calculator_tb.sv */
`timescale 1ns / 1ps

module svpwm_compare_calculator_tb;
	import svpwm_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 24;
	localparam int RANDOM_PER_PERIOD = 255;

	typedef struct {
		logic opcode;
		logic signed [DATA_W-1:0] alpha;
		logic signed [DATA_W-1:0] beta;
		logic [2:0] vec_num;
		logic signed [DATA_W-1:0] power;
	} vector_req_t;

	typedef struct {
		logic [15:0] cmp_a;
		logic [15:0] cmp_b;
		logic [15:0] cmp_c;
		logic [2:0] sector;
		logic signed [DATA_W-1:0] ref_one;
		logic signed [DATA_W-1:0] ref_two;
		logic signed [DATA_W-1:0] ref_three;
		logic ovm;
	} compare_set_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic opcode;
	logic signed [DATA_W-1:0] alpha_in;
	logic signed [DATA_W-1:0] beta_in;
	logic [2:0] vector_number;
	logic signed [DATA_W-1:0] power_level;
	logic cfg_we;
	logic [PER_W-1:0] cfg_wdata;
	logic done;
	logic [15:0] compare_a;
	logic [15:0] compare_b;
	logic [15:0] compare_c;
	logic [2:0] sector_out;
	logic signed [DATA_W-1:0] phase_ref_one;
	logic signed [DATA_W-1:0] phase_ref_two;
	logic signed [DATA_W-1:0] phase_ref_three;
	logic overmodulation;

	vector_req_t pending_reqs[$];
	compare_set_t expected_compares[$];
	longint period_copy;
	int error_count;
	int idle_cycles;
	int burst_left;
	int gap_left;
	logic req_taken;

	// per sector: active-time references, negation, middle order, phase roles
	ref_sel_t lead_ref[7] = '{REF_ONE, REF_ONE, REF_THREE, REF_TWO, REF_ONE, REF_THREE, REF_TWO};
	ref_sel_t trail_ref[7] = '{REF_ONE, REF_THREE, REF_TWO, REF_ONE, REF_THREE, REF_TWO, REF_ONE};
	bit flip_refs[7] = '{0, 0, 1, 0, 1, 0, 1};
	role_t phase_a_role[7] = '{ROLE_MIN, ROLE_MIN, ROLE_MID, ROLE_MAX, ROLE_MAX, ROLE_MID, ROLE_MIN};
	role_t phase_b_role[7] = '{ROLE_MIN, ROLE_MID, ROLE_MIN, ROLE_MIN, ROLE_MID, ROLE_MAX, ROLE_MAX};
	role_t phase_c_role[7] = '{ROLE_MIN, ROLE_MAX, ROLE_MAX, ROLE_MID, ROLE_MIN, ROLE_MIN, ROLE_MID};

	svpwm_compare_calculator dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.alpha_in(alpha_in),
		.beta_in(beta_in),
		.vector_number(vector_number),
		.power_level(power_level),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.done(done),
		.compare_a(compare_a),
		.compare_b(compare_b),
		.compare_c(compare_c),
		.sector_out(sector_out),
		.phase_ref_one(phase_ref_one),
		.phase_ref_two(phase_ref_two),
		.phase_ref_three(phase_ref_three),
		.overmodulation(overmodulation)
	);

	always #1 clk = ~clk;

	function automatic longint frac_trunc(longint x);
		if (x < 0) begin
			return -((-x) >>> FRAC_BITS);
		end
		return x >>> FRAC_BITS;
	endfunction

	function automatic logic signed [DATA_W-1:0] clip_signed(longint x);
		if (x > 32767) begin
			return 16'sh7fff;
		end
		if (x < -32768) begin
			return 16'sh8000;
		end
		return DATA_W'(x);
	endfunction

	function automatic logic [15:0] clip_ticks(longint x);
		return (x > 65535) ? 16'hffff : 16'(x);
	endfunction

	function automatic compare_set_t predict_compares(vector_req_t r, longint per);
		compare_set_t res;
		longint one_q, a, b, p, ph, ps, q, n, half_b, sa, r1, r2, t1, t2, tmin, tvar, tmax;
		longint refs[3];
		longint ticks[3];
		int pseudo;
		int sec;
		one_q = longint'(ONE);
		if (r.opcode == OP_AB) begin
			a = r.alpha;
			b = r.beta;
		end else begin
			p = r.power;
			if (p > one_q) p = one_q;
			if (p < -one_q) p = -one_q;
			ph = p / 2;
			ps = frac_trunc(p * SQ3H);
			case (r.vec_num)
				3'd1: begin a = p; b = 0; end
				3'd2: begin a = ph; b = ps; end
				3'd3: begin a = -ph; b = ps; end
				3'd4: begin a = -p; b = 0; end
				3'd5: begin a = -ph; b = -ps; end
				3'd6: begin a = ph; b = -ps; end
				default: begin a = 0; b = 0; end
			endcase
		end
		q = a * a + b * b;
		if (q > (one_q << FRAC_BITS)) begin
			n = q >>> FRAC_BITS;
			a = (a * one_q) / n;
			b = (b * one_q) / n;
		end
		half_b = -(b / 2);
		sa = frac_trunc(longint'(SQ3H) * a);
		refs[0] = b;
		refs[1] = half_b - sa;
		refs[2] = half_b + sa;
		pseudo = (refs[0] > 0 ? 1 : 0) + (refs[2] > 0 ? 2 : 0) + (refs[1] > 0 ? 4 : 0);
		case (pseudo)
			1: sec = 2;
			2: sec = 6;
			3: sec = 1;
			4: sec = 4;
			5: sec = 3;
			6: sec = 5;
			default: sec = SEC_ZERO;
		endcase
		res.cmp_a = '0;
		res.cmp_b = '0;
		res.cmp_c = '0;
		res.ovm = 1'b0;
		if (sec != SEC_ZERO) begin
			r1 = refs[int'(lead_ref[sec])];
			r2 = refs[int'(trail_ref[sec])];
			if (flip_refs[sec]) begin
				r1 = -r1;
				r2 = -r2;
			end
			t1 = frac_trunc(r1 * per);
			t2 = frac_trunc(r2 * per);
			if (t1 < 0) t1 = 0;
			if (t2 < 0) t2 = 0;
			if (t1 + t2 > per) begin
				tmin = 0;
				res.ovm = 1'b1;
			end else begin
				tmin = (per - t1 - t2) / 2;
			end
			if (flip_refs[sec]) begin
				tvar = tmin + t1;
				tmax = tvar + t2;
			end else begin
				tvar = tmin + t2;
				tmax = tvar + t1;
			end
			ticks[int'(ROLE_MIN)] = tmin;
			ticks[int'(ROLE_MID)] = tvar;
			ticks[int'(ROLE_MAX)] = tmax;
			res.cmp_a = clip_ticks(ticks[int'(phase_a_role[sec])]);
			res.cmp_b = clip_ticks(ticks[int'(phase_b_role[sec])]);
			res.cmp_c = clip_ticks(ticks[int'(phase_c_role[sec])]);
		end
		res.sector = 3'(sec);
		res.ref_one = clip_signed(refs[0]);
		res.ref_two = clip_signed(refs[1]);
		res.ref_three = clip_signed(refs[2]);
		return res;
	endfunction

	task automatic report_mismatch(string field, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
		error_count++;
	endtask

	task automatic add_request(logic op, int a, int b, int vn, int pw);
		vector_req_t r;
		r.opcode = op;
		r.alpha = DATA_W'(a);
		r.beta = DATA_W'(b);
		r.vec_num = 3'(vn);
		r.power = DATA_W'(pw);
		pending_reqs.push_back(r);
	endtask

	task automatic add_random_request();
		int mode;
		int lim;
		mode = $urandom_range(0, 9);
		lim = (mode < 5) ? ONE : ((mode < 7) ? 32767 : 64);
		if ($urandom_range(0, 2) == 0) begin
			add_request(OP_BASIC, $urandom, $urandom, $urandom_range(0, 7),
				(mode < 6) ? $urandom_range(0, 2 * ONE) - ONE : int'($urandom));
		end else if (lim == 32767) begin
			add_request(OP_AB, int'($urandom), int'($urandom), $urandom, $urandom);
		end else begin
			add_request(OP_AB, $urandom_range(0, 2 * lim) - lim, $urandom_range(0, 2 * lim) - lim,
				$urandom, $urandom);
		end
	endtask

	// wait until every request has come back, then let the pipeline settle
	task automatic drain_pipeline();
		while (pending_reqs.size() != 0 || start || expected_compares.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_period(int value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= PER_W'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
		period_copy = value;
	endtask

	// request driver with bursts and gaps
	always @(negedge clk) begin
		if (arst_n && (!start || req_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending_reqs.size() != 0) begin
				opcode <= pending_reqs[0].opcode;
				alpha_in <= pending_reqs[0].alpha;
				beta_in <= pending_reqs[0].beta;
				vector_number <= pending_reqs[0].vec_num;
				power_level <= pending_reqs[0].power;
				void'(pending_reqs.pop_front());
				start <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 30);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: predict on accepted request, check on done
	always @(posedge clk) begin
		compare_set_t want;
		vector_req_t r;
		req_taken <= start && !busy;
		if (arst_n) begin
			if ((start && !busy) || done) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
		if (start && !busy) begin
			r.opcode = opcode;
			r.alpha = alpha_in;
			r.beta = beta_in;
			r.vec_num = vector_number;
			r.power = power_level;
			expected_compares.push_back(predict_compares(r, period_copy));
		end
		if (done) begin
			if (expected_compares.size() == 0) begin
				$display("unexpected result at %0t", $realtime);
				error_count++;
			end else begin
				want = expected_compares.pop_front();
				if (compare_a !== want.cmp_a) report_mismatch("compare_a", compare_a, want.cmp_a);
				if (compare_b !== want.cmp_b) report_mismatch("compare_b", compare_b, want.cmp_b);
				if (compare_c !== want.cmp_c) report_mismatch("compare_c", compare_c, want.cmp_c);
				if (sector_out !== want.sector) report_mismatch("sector_out", sector_out, want.sector);
				if (phase_ref_one !== want.ref_one)
					report_mismatch("phase_ref_one", phase_ref_one, want.ref_one);
				if (phase_ref_two !== want.ref_two)
					report_mismatch("phase_ref_two", phase_ref_two, want.ref_two);
				if (phase_ref_three !== want.ref_three)
					report_mismatch("phase_ref_three", phase_ref_three, want.ref_three);
				if (overmodulation !== want.ovm)
					report_mismatch("overmodulation", overmodulation, want.ovm);
			end
		end
	end

	initial begin
		int periods[6];
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		opcode = OP_AB;
		alpha_in = '0;
		beta_in = '0;
		vector_number = '0;
		power_level = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_taken = 1'b0;
		period_copy = 4096;
		error_count = 0;
		idle_cycles = 0;
		burst_left = 0;
		gap_left = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: every basic vector, power clamp, extreme and zero vectors
		for (int v = 0; v < 8; v++) begin
			add_request(OP_BASIC, 0, 0, v, ONE);
		end
		add_request(OP_BASIC, -1, -1, 2, 32767);
		add_request(OP_BASIC, 0, 0, 5, -32768);
		add_request(OP_BASIC, 0, 0, 3, -ONE);
		add_request(OP_BASIC, 0, 0, 7, 32767);
		add_request(OP_AB, 32767, 32767, 0, 0);
		add_request(OP_AB, -32768, -32768, 7, -1);
		add_request(OP_AB, 32767, -32768, 0, 0);
		add_request(OP_AB, 0, 0, 0, 0);
		add_request(OP_AB, ONE, 0, 0, 0);
		add_request(OP_AB, 0, -ONE, 0, 0);
		add_request(OP_AB, 1, 1, 0, 0);
		add_request(OP_AB, -1, 0, 0, 0);
		add_request(OP_AB, 11585, 11585, 0, 0);
		add_request(OP_AB, 0, 32767, 0, 0);
		drain_pipeline();

		periods = '{65535, 1, 0, 4096, 1000, 0};
		periods[5] = $urandom_range(2, 65534);
		foreach (periods[k]) begin
			write_period(periods[k]);
			for (int i = 0; i < RANDOM_PER_PERIOD; i++) begin
				add_random_request();
				if (i == RANDOM_PER_PERIOD / 2) begin
					drain_pipeline();
				end
			end
			drain_pipeline();
		end

		if (error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
